### rtl/core/clil_pkg.sv
// shared types, codes and character helpers for the integer literal classifier
package clil_pkg;

  typedef enum logic [11:0] {
    PH_START   = 12'b0000_0000_0001,
    PH_ZERO    = 12'b0000_0000_0010,
    PH_ZX      = 12'b0000_0000_0100,
    PH_HEX     = 12'b0000_0000_1000,
    PH_OCT     = 12'b0000_0001_0000,
    PH_DEC     = 12'b0000_0010_0000,
    PH_SUF     = 12'b0000_0100_0000,
    PH_FRAC    = 12'b0000_1000_0000,
    PH_EXP     = 12'b0001_0000_0000,
    PH_EXPSIGN = 12'b0010_0000_0000,
    PH_FDONE   = 12'b0100_0000_0000,
    PH_EXPBAD  = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  localparam logic [1:0] SUF_NONE = 2'b00;
  localparam logic [1:0] SUF_U    = 2'b01;
  localparam logic [1:0] SUF_L    = 2'b10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_BAD_OCT   = 3'd2;
  localparam logic [2:0] ST_BAD_SUF   = 3'd3;
  localparam logic [2:0] ST_NO_EXP    = 3'd4;

  localparam logic [1:0] TY_INT      = 2'd0;
  localparam logic [1:0] TY_UINT     = 2'd1;
  localparam logic [1:0] TY_LONG     = 2'd2;
  localparam logic [1:0] TY_UNS_LONG = 2'd3;

  localparam logic KIND_INT   = 1'b0;
  localparam logic KIND_FLOAT = 1'b1;

  localparam logic [1:0] CFG_INT_MAX   = 2'd0;
  localparam logic [1:0] CFG_UINT_MAX  = 2'd1;
  localparam logic [1:0] CFG_LONG_MAX  = 2'd2;
  localparam logic [1:0] CFG_ULONG_MAX = 2'd3;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_UC_E  = 8'h45;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_UC_U  = 8'h55;
  localparam logic [7:0] CH_LC_L  = 8'h6c;
  localparam logic [7:0] CH_UC_L  = 8'h4c;

  // final scan state of one token, handed to the classifier
  typedef struct packed {
    phase_e     phase;
    radix_e     radix;
    logic [1:0] suffix;
    logic       overflowed;
    logic       octal_bad;
    logic       tail_bad;
  } tok_t;

  // {valid, digit value} of a hex digit character
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### rtl/core/clil_scan.sv
// character scanner: input register, per-token scan state and end-of-token snapshot
module clil_scan #(
  parameter int VALUE_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  input  logic [7:0]             ch_i,
  input  logic                   last_i,
  output logic                   tok_valid_o,
  output clil_pkg::tok_t         tok_o,
  output logic [VALUE_BITS-1:0]  tok_acc_o
);

  localparam int WB = VALUE_BITS + 4;

  logic                  in_valid_q;
  logic [7:0]            ch_q;
  logic                  last_q;

  clil_pkg::phase_e      phase_q, phase_d;
  clil_pkg::radix_e      radix_q, radix_d;
  logic [1:0]            suffix_q, suffix_d;
  logic                  overflowed_q, overflowed_d;
  logic                  octal_bad_q, octal_bad_d;
  logic                  tail_bad_q, tail_bad_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  logic                  tok_valid_q;
  clil_pkg::tok_t        tok_q, tok_d;
  logic [VALUE_BITS-1:0] tok_acc_q;

  logic                  is_dec;
  logic [4:0]            hx;
  logic [WB-1:0]         dec_sum;
  logic                  dec_ov;
  logic                  oct_ov;
  logic                  hex_ov;
  logic [VALUE_BITS-1:0] oct_res;
  logic [VALUE_BITS-1:0] hex_res;
  logic                  do_dec, do_oct, do_hex, do_suf, do_after;
  logic [1:0]            suf_bit;
  logic                  step;

  assign step   = adv_i && in_valid_q;
  assign is_dec = (ch_q >= clil_pkg::CH_0) && (ch_q <= clil_pkg::CH_9);
  assign hx     = clil_pkg::hex_digit(ch_q);

  // accumulate steps: times ten, times eight, times sixteen
  assign dec_sum = (WB'(acc_q) << 3) + (WB'(acc_q) << 1) + WB'(ch_q[3:0]);
  assign dec_ov  = |dec_sum[WB-1:VALUE_BITS];
  assign oct_ov  = |acc_q[VALUE_BITS-1:VALUE_BITS-3];
  assign hex_ov  = |acc_q[VALUE_BITS-1:VALUE_BITS-4];
  assign oct_res = {acc_q[VALUE_BITS-4:0], 3'b000} + VALUE_BITS'(ch_q[3:0]);
  assign hex_res = {acc_q[VALUE_BITS-5:0], hx[3:0]};

  always_comb begin
    phase_d      = phase_q;
    radix_d      = radix_q;
    suffix_d     = suffix_q;
    overflowed_d = overflowed_q;
    octal_bad_d  = octal_bad_q;
    tail_bad_d   = tail_bad_q;
    acc_d        = acc_q;
    do_dec       = 1'b0;
    do_oct       = 1'b0;
    do_hex       = 1'b0;
    do_suf       = 1'b0;
    do_after     = 1'b0;
    suf_bit      = clil_pkg::SUF_NONE;

    case (phase_q)
      clil_pkg::PH_START: begin
        if (ch_q == clil_pkg::CH_0) begin
          phase_d = clil_pkg::PH_ZERO;
          radix_d = clil_pkg::RADIX_OCT;
        end else begin
          phase_d  = clil_pkg::PH_DEC;
          do_dec   = is_dec;
          do_after = !is_dec;
        end
      end
      clil_pkg::PH_DEC: begin
        do_dec   = is_dec;
        do_after = !is_dec;
      end
      clil_pkg::PH_ZERO: begin
        if (ch_q == clil_pkg::CH_LC_X || ch_q == clil_pkg::CH_UC_X) begin
          phase_d = clil_pkg::PH_ZX;
        end else begin
          phase_d  = clil_pkg::PH_OCT;
          do_oct   = is_dec;
          do_after = !is_dec;
        end
      end
      clil_pkg::PH_OCT: begin
        do_oct   = is_dec;
        do_after = !is_dec;
      end
      clil_pkg::PH_ZX: begin
        if (hx[4]) begin
          radix_d = clil_pkg::RADIX_HEX;
          phase_d = clil_pkg::PH_HEX;
          do_hex  = 1'b1;
        end else begin
          phase_d    = clil_pkg::PH_SUF;
          tail_bad_d = 1'b1;
        end
      end
      clil_pkg::PH_HEX: begin
        do_hex = hx[4];
        do_suf = !hx[4];
      end
      clil_pkg::PH_SUF: begin
        do_suf = 1'b1;
      end
      clil_pkg::PH_FRAC: begin
        if (ch_q == clil_pkg::CH_LC_E || ch_q == clil_pkg::CH_UC_E) begin
          phase_d = clil_pkg::PH_EXP;
        end else if (!is_dec) begin
          phase_d = clil_pkg::PH_FDONE;
        end
      end
      clil_pkg::PH_EXP: begin
        if (ch_q == clil_pkg::CH_PLUS || ch_q == clil_pkg::CH_MINUS) begin
          phase_d = clil_pkg::PH_EXPSIGN;
        end else begin
          phase_d = is_dec ? clil_pkg::PH_FDONE : clil_pkg::PH_EXPBAD;
        end
      end
      clil_pkg::PH_EXPSIGN: begin
        phase_d = is_dec ? clil_pkg::PH_FDONE : clil_pkg::PH_EXPBAD;
      end
      default: begin
      end
    endcase

    // character after a decimal or octal run
    if (do_after) begin
      if (ch_q == clil_pkg::CH_DOT) begin
        phase_d = clil_pkg::PH_FRAC;
      end else if (ch_q == clil_pkg::CH_LC_E || ch_q == clil_pkg::CH_UC_E) begin
        phase_d = clil_pkg::PH_EXP;
      end else begin
        do_suf = 1'b1;
      end
    end

    if (do_suf) begin
      phase_d = clil_pkg::PH_SUF;
      if (ch_q == clil_pkg::CH_LC_U || ch_q == clil_pkg::CH_UC_U) begin
        suf_bit = clil_pkg::SUF_U;
      end else if (ch_q == clil_pkg::CH_LC_L || ch_q == clil_pkg::CH_UC_L) begin
        suf_bit = clil_pkg::SUF_L;
      end
      if (!tail_bad_q) begin
        if (suf_bit == clil_pkg::SUF_NONE || (suffix_q & suf_bit) != clil_pkg::SUF_NONE) begin
          tail_bad_d = 1'b1;
        end else begin
          suffix_d = suffix_q | suf_bit;
        end
      end
    end

    if (do_dec) begin
      if (dec_ov) overflowed_d = 1'b1;
      else        acc_d = dec_sum[VALUE_BITS-1:0];
    end

    if (do_oct) begin
      if (ch_q > clil_pkg::CH_7) octal_bad_d = 1'b1;
      if (oct_ov) overflowed_d = 1'b1;
      else        acc_d = oct_res;
    end

    if (do_hex) begin
      if (hex_ov) overflowed_d = 1'b1;
      else        acc_d = hex_res;
    end
  end

  always_comb begin
    tok_d.phase      = phase_d;
    tok_d.radix      = radix_d;
    tok_d.suffix     = suffix_d;
    tok_d.overflowed = overflowed_d;
    tok_d.octal_bad  = octal_bad_d;
    tok_d.tail_bad   = tail_bad_d;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_i) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  // scan state, back to start of token after the last beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= clil_pkg::PH_START;
      radix_q      <= clil_pkg::RADIX_DEC;
      suffix_q     <= clil_pkg::SUF_NONE;
      overflowed_q <= 1'b0;
      octal_bad_q  <= 1'b0;
      tail_bad_q   <= 1'b0;
      acc_q        <= '0;
    end else if (step) begin
      if (last_q) begin
        phase_q      <= clil_pkg::PH_START;
        radix_q      <= clil_pkg::RADIX_DEC;
        suffix_q     <= clil_pkg::SUF_NONE;
        overflowed_q <= 1'b0;
        octal_bad_q  <= 1'b0;
        tail_bad_q   <= 1'b0;
        acc_q        <= '0;
      end else begin
        phase_q      <= phase_d;
        radix_q      <= radix_d;
        suffix_q     <= suffix_d;
        overflowed_q <= overflowed_d;
        octal_bad_q  <= octal_bad_d;
        tail_bad_q   <= tail_bad_d;
        acc_q        <= acc_d;
      end
    end
  end

  // end-of-token snapshot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else if (adv_i) begin
      tok_valid_q <= in_valid_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      tok_q     <= tok_d;
      tok_acc_q <= acc_d;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;
  assign tok_acc_o   = tok_acc_q;

  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == clil_pkg::PH_START |->
      acc_q == '0 && !overflowed_q && !tail_bad_q && suffix_q == clil_pkg::SUF_NONE)
    else $error("scan state not clear at start of token");

  a_octal_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    octal_bad_q |-> radix_q == clil_pkg::RADIX_OCT)
    else $error("bad octal digit flagged outside an octal run");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && last_q |=> phase_q == clil_pkg::PH_START && tok_valid_q)
    else $error("last beat did not close the token");

endmodule

### rtl/core/clil_class.sv
// type selection against target limits and the result register
module clil_class #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  tok_valid_i,
  input  clil_pkg::tok_t        tok_i,
  input  logic [VALUE_BITS-1:0] tok_acc_i,
  input  logic [62:0]           int_max_i,
  input  logic [63:0]           uint_max_i,
  input  logic [62:0]           long_max_i,
  input  logic [63:0]           ulong_max_i,
  output logic                  out_valid_o,
  output logic                  token_kind_o,
  output logic [1:0]            type_code_o,
  output logic [63:0]           value_o,
  output logic [2:0]            status_o
);

  logic        out_valid_q;
  logic        kind_q, kind_d;
  logic [1:0]  type_q, type_d;
  logic [63:0] value_q, value_d;
  logic [2:0]  status_q, status_d;

  logic [63:0] acc64;
  logic        fits_int, fits_uint, fits_long, fits_ulong;
  logic        found;
  logic [1:0]  pick;

  assign acc64      = 64'(tok_acc_i);
  assign fits_int   = acc64 <= {1'b0, int_max_i};
  assign fits_uint  = acc64 <= uint_max_i;
  assign fits_long  = acc64 <= {1'b0, long_max_i};
  assign fits_ulong = acc64 <= ulong_max_i;

  // first type in the suffix's list that holds the value
  always_comb begin
    found = 1'b1;
    pick  = clil_pkg::TY_UNS_LONG;
    case (tok_i.suffix)
      clil_pkg::SUF_NONE: begin
        if (fits_int)                                            pick = clil_pkg::TY_INT;
        else if (tok_i.radix != clil_pkg::RADIX_DEC && fits_uint) pick = clil_pkg::TY_UINT;
        else if (fits_long)                                      pick = clil_pkg::TY_LONG;
        else                                                     found = fits_ulong;
      end
      clil_pkg::SUF_U: begin
        if (fits_uint) pick = clil_pkg::TY_UINT;
        else           found = fits_ulong;
      end
      clil_pkg::SUF_L: begin
        if (fits_long) pick = clil_pkg::TY_LONG;
        else           found = fits_ulong;
      end
      default: begin
        found = fits_ulong;
      end
    endcase
  end

  always_comb begin
    kind_d   = clil_pkg::KIND_INT;
    type_d   = clil_pkg::TY_INT;
    value_d  = '0;
    status_d = clil_pkg::ST_OK;
    if (tok_i.phase inside {clil_pkg::PH_FRAC, clil_pkg::PH_EXP, clil_pkg::PH_EXPSIGN,
                            clil_pkg::PH_FDONE, clil_pkg::PH_EXPBAD}) begin
      kind_d = clil_pkg::KIND_FLOAT;
      if (tok_i.phase inside {clil_pkg::PH_EXP, clil_pkg::PH_EXPSIGN, clil_pkg::PH_EXPBAD}) begin
        status_d = clil_pkg::ST_NO_EXP;
      end
    end else if (tok_i.octal_bad) begin
      status_d = clil_pkg::ST_BAD_OCT;
    end else if (tok_i.tail_bad || tok_i.phase == clil_pkg::PH_ZX) begin
      status_d = clil_pkg::ST_BAD_SUF;
    end else if (tok_i.overflowed || !found) begin
      type_d   = clil_pkg::TY_UNS_LONG;
      value_d  = ulong_max_i;
      status_d = clil_pkg::ST_TOO_LARGE;
    end else begin
      type_d  = pick;
      value_d = acc64;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && tok_valid_i) begin
      kind_q   <= kind_d;
      type_q   <= type_d;
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign token_kind_o = kind_q;
  assign type_code_o  = type_q;
  assign value_o      = value_q;
  assign status_o     = status_q;

  a_float_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == clil_pkg::KIND_FLOAT |->
      type_q == clil_pkg::TY_INT && value_q == '0)
    else $error("floating token with nonzero type or value");

  a_large_ulong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == clil_pkg::ST_TOO_LARGE |-> type_q == clil_pkg::TY_UNS_LONG)
    else $error("saturated constant not typed unsigned long");

endmodule

### rtl/core/c_integer_literal_classifier.sv
// top level of the integer literal classifier: limit registers and beat flow control
// result beats pass the input register, end-of-token snapshot and result register
// throughput: one character beat per cycle unless a result beat sits stalled
// a result waiting on the output stalls the input only while out_stall_i is high
// reset clears the scan state and all valid flags and loads the 32-bit target limits
module c_integer_literal_classifier #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        token_kind_o,
  output logic [1:0]  type_code_o,
  output logic [63:0] value_o,
  output logic [2:0]  status_o
);

  logic [62:0]           int_max_q;
  logic [63:0]           uint_max_q;
  logic [62:0]           long_max_q;
  logic [63:0]           ulong_max_q;

  logic                  adv;
  logic                  tok_valid;
  clil_pkg::tok_t        tok;
  logic [VALUE_BITS-1:0] tok_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_max_q   <= 63'd2147483647;
      uint_max_q  <= 64'd4294967295;
      long_max_q  <= 63'd2147483647;
      ulong_max_q <= 64'd4294967295;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clil_pkg::CFG_INT_MAX:   int_max_q   <= cfg_wdata_i[62:0];
        clil_pkg::CFG_UINT_MAX:  uint_max_q  <= cfg_wdata_i;
        clil_pkg::CFG_LONG_MAX:  long_max_q  <= cfg_wdata_i[62:0];
        clil_pkg::CFG_ULONG_MAX: ulong_max_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // whole pipe moves unless a result beat sits stalled
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  clil_scan #(
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (in_valid_i),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_acc_o   (tok_acc)
  );

  clil_class #(
    .VALUE_BITS (VALUE_BITS)
  ) u_class (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .tok_valid_i  (tok_valid),
    .tok_i        (tok),
    .tok_acc_i    (tok_acc),
    .int_max_i    (int_max_q),
    .uint_max_i   (uint_max_q),
    .long_max_i   (long_max_q),
    .ulong_max_i  (ulong_max_q),
    .out_valid_o  (out_valid_o),
    .token_kind_o (token_kind_o),
    .type_code_o  (type_code_o),
    .value_o      (value_o),
    .status_o     (status_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result beat");

endmodule

### test/tb_top.sv
// self-checking bench for the integer literal classifier: random spellings, limit sweeps, stalls
module tb_top;

  localparam int              LIMIT_CYCLES = 100000;
  localparam logic [63:0]     VMASK        = {64{1'b1}};
  localparam logic [63:0]     LIM63        = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  ty;
    logic [63:0] value;
    logic [2:0]  status;
  } lit_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = clil_pkg::CFG_INT_MAX;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i        = '0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        token_kind_o;
  logic [1:0]  type_code_o;
  logic [63:0] value_o;
  logic [2:0]  status_o;

  c_integer_literal_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .token_kind_o(token_kind_o),
    .type_code_o (type_code_o),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  char_beat_t  char_q[$];
  lit_result_t tokens_due[$];
  logic [7:0]  spell[$];
  char_beat_t  next_beat;
  lit_result_t due_tok;
  int          pushed_chars = 0;
  int          chars_taken  = 0;
  int          mismatches   = 0;
  int          cycle_cnt    = 0;
  int          hold_left    = 0;
  logic        hold_done    = 1'b0;
  wire         quiet        = (chars_taken >= 900) && (chars_taken < 1300);

  // target limits as the block holds them
  logic [63:0] lim_int   = 64'd2147483647;
  logic [63:0] lim_uint  = 64'd4294967295;
  logic [63:0] lim_long  = 64'd2147483647;
  logic [63:0] lim_ulong = 64'd4294967295;

  // scan state of the token in flight
  logic [63:0]      acc       = '0;
  logic             ovf       = 1'b0;
  clil_pkg::radix_e rdx       = clil_pkg::RADIX_DEC;
  clil_pkg::phase_e ph        = clil_pkg::PH_START;
  logic [1:0]       sfx       = clil_pkg::SUF_NONE;
  logic             bad_oct   = 1'b0;
  logic             junk_seen = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= clil_pkg::CH_0 && c <= clil_pkg::CH_9;
  endfunction

  function automatic int hex_of(input logic [7:0] c);
    if (is_digit(c)) return int'(c - clil_pkg::CH_0);
    if (c >= clil_pkg::CH_LC_A && c <= clil_pkg::CH_LC_F) return int'(c - clil_pkg::CH_LC_A) + 10;
    if (c >= clil_pkg::CH_UC_A && c <= clil_pkg::CH_UC_F) return int'(c - clil_pkg::CH_UC_A) + 10;
    return -1;
  endfunction

  task automatic shift_in(input int sh, input logic [63:0] d);
    if ((acc & ~(VMASK >> sh)) != 0) begin
      ovf = 1'b1;
    end else begin
      acc = (acc << sh) + d;
    end
  endtask

  task automatic take_suffix(input logic [7:0] c);
    logic [1:0] sbit;
    sbit = clil_pkg::SUF_NONE;
    ph = clil_pkg::PH_SUF;
    if (!junk_seen) begin
      if (c == clil_pkg::CH_LC_U || c == clil_pkg::CH_UC_U) begin
        sbit = clil_pkg::SUF_U;
      end else if (c == clil_pkg::CH_LC_L || c == clil_pkg::CH_UC_L) begin
        sbit = clil_pkg::SUF_L;
      end
      if (sbit == clil_pkg::SUF_NONE || (sfx & sbit) != 0) begin
        junk_seen = 1'b1;
      end else begin
        sfx = sfx | sbit;
      end
    end
  endtask

  task automatic end_of_run(input logic [7:0] c);
    if (c == clil_pkg::CH_DOT) begin
      ph = clil_pkg::PH_FRAC;
    end else if (c == clil_pkg::CH_LC_E || c == clil_pkg::CH_UC_E) begin
      ph = clil_pkg::PH_EXP;
    end else begin
      take_suffix(c);
    end
  endtask

  task automatic take_dec(input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - clil_pkg::CH_0);
    if (is_digit(c)) begin
      if (acc > (VMASK - d) / 64'd10) begin
        ovf = 1'b1;
      end else begin
        acc = 64'd10 * acc + d;
      end
    end else begin
      end_of_run(c);
    end
  endtask

  task automatic take_oct(input logic [7:0] c);
    if (is_digit(c)) begin
      if (c > clil_pkg::CH_7) bad_oct = 1'b1;
      shift_in(3, 64'(c - clil_pkg::CH_0));
    end else begin
      end_of_run(c);
    end
  endtask

  // advance the scan by one character, queue the expected result on the last one
  task automatic lex_char(input logic [7:0] c, input logic lst);
    int          h;
    logic        fits;
    lit_result_t res;
    h = hex_of(c);
    case (ph)
      clil_pkg::PH_START: begin
        if (c == clil_pkg::CH_0) begin
          ph = clil_pkg::PH_ZERO;
          rdx = clil_pkg::RADIX_OCT;
        end else begin
          ph = clil_pkg::PH_DEC;
          take_dec(c);
        end
      end
      clil_pkg::PH_DEC: take_dec(c);
      clil_pkg::PH_ZERO: begin
        if (c == clil_pkg::CH_LC_X || c == clil_pkg::CH_UC_X) begin
          ph = clil_pkg::PH_ZX;
        end else begin
          ph = clil_pkg::PH_OCT;
          take_oct(c);
        end
      end
      clil_pkg::PH_OCT: take_oct(c);
      clil_pkg::PH_ZX: begin
        if (h >= 0) begin
          rdx = clil_pkg::RADIX_HEX;
          ph = clil_pkg::PH_HEX;
          shift_in(4, 64'(h));
        end else begin
          ph = clil_pkg::PH_SUF;
          junk_seen = 1'b1;
        end
      end
      clil_pkg::PH_HEX: begin
        if (h >= 0) begin
          shift_in(4, 64'(h));
        end else begin
          take_suffix(c);
        end
      end
      clil_pkg::PH_SUF: take_suffix(c);
      clil_pkg::PH_FRAC: begin
        if (c == clil_pkg::CH_LC_E || c == clil_pkg::CH_UC_E) begin
          ph = clil_pkg::PH_EXP;
        end else if (!is_digit(c)) begin
          ph = clil_pkg::PH_FDONE;
        end
      end
      clil_pkg::PH_EXP: begin
        if (c == clil_pkg::CH_PLUS || c == clil_pkg::CH_MINUS) begin
          ph = clil_pkg::PH_EXPSIGN;
        end else begin
          ph = is_digit(c) ? clil_pkg::PH_FDONE : clil_pkg::PH_EXPBAD;
        end
      end
      clil_pkg::PH_EXPSIGN: ph = is_digit(c) ? clil_pkg::PH_FDONE : clil_pkg::PH_EXPBAD;
      default: ;
    endcase
    if (lst) begin
      res.kind = clil_pkg::KIND_INT;
      res.ty = clil_pkg::TY_INT;
      res.value = '0;
      res.status = clil_pkg::ST_OK;
      fits = 1'b1;
      case (ph)
        clil_pkg::PH_FRAC, clil_pkg::PH_FDONE: res.kind = clil_pkg::KIND_FLOAT;
        clil_pkg::PH_EXP, clil_pkg::PH_EXPSIGN, clil_pkg::PH_EXPBAD: begin
          res.kind = clil_pkg::KIND_FLOAT;
          res.status = clil_pkg::ST_NO_EXP;
        end
        default: begin
          if (bad_oct) begin
            res.status = clil_pkg::ST_BAD_OCT;
          end else if (junk_seen || ph == clil_pkg::PH_ZX) begin
            res.status = clil_pkg::ST_BAD_SUF;
          end else begin
            case (sfx)
              clil_pkg::SUF_NONE: begin
                if (acc <= lim_int) res.ty = clil_pkg::TY_INT;
                else if (rdx != clil_pkg::RADIX_DEC && acc <= lim_uint) res.ty = clil_pkg::TY_UINT;
                else if (acc <= lim_long) res.ty = clil_pkg::TY_LONG;
                else if (acc <= lim_ulong) res.ty = clil_pkg::TY_UNS_LONG;
                else fits = 1'b0;
              end
              clil_pkg::SUF_U: begin
                if (acc <= lim_uint) res.ty = clil_pkg::TY_UINT;
                else if (acc <= lim_ulong) res.ty = clil_pkg::TY_UNS_LONG;
                else fits = 1'b0;
              end
              clil_pkg::SUF_L: begin
                if (acc <= lim_long) res.ty = clil_pkg::TY_LONG;
                else if (acc <= lim_ulong) res.ty = clil_pkg::TY_UNS_LONG;
                else fits = 1'b0;
              end
              default: begin
                if (acc <= lim_ulong) res.ty = clil_pkg::TY_UNS_LONG;
                else fits = 1'b0;
              end
            endcase
            if (ovf || !fits) begin
              res.ty = clil_pkg::TY_UNS_LONG;
              res.value = lim_ulong;
              res.status = clil_pkg::ST_TOO_LARGE;
            end else begin
              res.value = acc;
            end
          end
        end
      endcase
      tokens_due.push_back(res);
      acc = '0;
      ovf = 1'b0;
      rdx = clil_pkg::RADIX_DEC;
      ph = clil_pkg::PH_START;
      sfx = clil_pkg::SUF_NONE;
      bad_oct = 1'b0;
      junk_seen = 1'b0;
    end
  endtask

  task automatic report_miss(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) return clil_pkg::CH_0 + d;
    return ($urandom_range(1) ? clil_pkg::CH_LC_A : clil_pkg::CH_UC_A) + d - 8'd10;
  endfunction

  task automatic send_spell();
    char_beat_t b;
    foreach (spell[i]) begin
      b.ch = spell[i];
      b.last = (i == spell.size() - 1);
      char_q.push_back(b);
      pushed_chars++;
    end
    spell.delete();
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) spell.push_back(s[i]);
    send_spell();
  endtask

  task automatic put_num(input logic [63:0] v, input logic [63:0] base);
    logic [7:0]  digs[$];
    logic [63:0] d;
    if (base == 64'd16) begin
      spell.push_back(clil_pkg::CH_0);
      spell.push_back($urandom_range(1) ? clil_pkg::CH_LC_X : clil_pkg::CH_UC_X);
    end else if (base == 64'd8) begin
      spell.push_back(clil_pkg::CH_0);
    end
    do begin
      d = v % base;
      digs.push_front(digit_char(d[3:0]));
      v = v / base;
    end while (v != 0);
    foreach (digs[i]) spell.push_back(digs[i]);
  endtask

  task automatic put_suffix();
    int r;
    int n;
    r = $urandom_range(9);
    n = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        spell.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(3))
          0: spell.push_back(clil_pkg::CH_LC_U);
          1: spell.push_back(clil_pkg::CH_UC_U);
          2: spell.push_back(clil_pkg::CH_LC_L);
          default: spell.push_back(clil_pkg::CH_UC_L);
        endcase
      end
    end
  endtask

  task automatic make_token();
    int          r;
    int          k;
    logic [63:0] v;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 5)) spell.push_back(8'($urandom_range(255)));
    end else if (r < 22) begin
      spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(1, 9)));
      repeat ($urandom_range(0, 21)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
      put_suffix();
    end else if (r < 32) begin
      spell.push_back(clil_pkg::CH_0);
      repeat ($urandom_range(0, 23)) begin
        if ($urandom_range(19) == 0) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(8, 9)));
        else spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(7)));
      end
      put_suffix();
    end else if (r < 44) begin
      spell.push_back(clil_pkg::CH_0);
      spell.push_back($urandom_range(1) ? clil_pkg::CH_LC_X : clil_pkg::CH_UC_X);
      repeat ($urandom_range(1, 17)) spell.push_back(digit_char(4'($urandom_range(15))));
      put_suffix();
    end else if (r < 70) begin
      // values right at and around the type limits, around zero, or random
      case ($urandom_range(5))
        0: v = lim_int;
        1: v = lim_uint;
        2: v = lim_long;
        3: v = lim_ulong;
        4: v = '0;
        default: v = rand_wide();
      endcase
      v = v + 64'($urandom_range(2)) - 64'd1;
      k = $urandom_range(2);
      put_num(v, (k == 0) ? 64'd10 : (k == 1) ? 64'd8 : 64'd16);
      put_suffix();
    end else if (r < 86) begin
      repeat ($urandom_range(0, 3)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
      k = $urandom_range(2);
      if (k != 2) begin
        spell.push_back(clil_pkg::CH_DOT);
        repeat ($urandom_range(0, 3)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
      end
      if (k != 0) begin
        spell.push_back($urandom_range(1) ? clil_pkg::CH_LC_E : clil_pkg::CH_UC_E);
        if ($urandom_range(1)) begin
          spell.push_back($urandom_range(1) ? clil_pkg::CH_PLUS : clil_pkg::CH_MINUS);
        end
        repeat ($urandom_range(0, 2)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
      end
      if ($urandom_range(4) == 0) spell.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: begin
          spell.push_back(clil_pkg::CH_0);
          spell.push_back($urandom_range(1) ? clil_pkg::CH_LC_X : clil_pkg::CH_UC_X);
          if ($urandom_range(1)) spell.push_back(8'($urandom_range(255)));
        end
        1: begin
          repeat ($urandom_range(1, 4)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
          spell.push_back(8'($urandom_range(255)));
          repeat ($urandom_range(0, 3)) spell.push_back(8'(clil_pkg::CH_0 + $urandom_range(9)));
        end
        default: begin
          put_num(rand_wide(), 64'd16);
          spell.push_back(8'($urandom_range(32, 126)));
          put_suffix();
        end
      endcase
    end
    send_spell();
  endtask

  task automatic run_random(input int nchars);
    int target;
    target = pushed_chars + nchars;
    while (pushed_chars < target) make_token();
  endtask

  task automatic drain();
    while (char_q.size() != 0 || in_valid_i || tokens_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      clil_pkg::CFG_INT_MAX:  lim_int = val & LIM63;
      clil_pkg::CFG_UINT_MAX: lim_uint = val;
      clil_pkg::CFG_LONG_MAX: lim_long = val & LIM63;
      default:                lim_ulong = val;
    endcase
  endtask

  // sender: character beats from char_q
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i <= '0;
      last_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        lex_char(ch_i, last_i);
        chars_taken <= chars_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (char_q.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
          next_beat = char_q.pop_front();
          in_valid_i <= 1'b1;
          ch_i <= next_beat.ch;
          last_i <= next_beat.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back up the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= (hold_left != 1);
    end else if (!hold_done && chars_taken >= 520) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tokens_due.size() == 0) begin
        report_miss("result beat with nothing due", '0, value_o);
      end else begin
        due_tok = tokens_due.pop_front();
        if (token_kind_o !== due_tok.kind) begin
          report_miss("token_kind", 64'(due_tok.kind), 64'(token_kind_o));
        end
        if (type_code_o !== due_tok.ty) report_miss("type_code", 64'(due_tok.ty), 64'(type_code_o));
        if (value_o !== due_tok.value) report_miss("value", due_tok.value, value_o);
        if (status_o !== due_tok.status) begin
          report_miss("status", 64'(due_tok.status), 64'(status_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    push_str("0");
    push_str("9");
    push_str("z");
    push_str("0x");
    push_str("08");
    push_str(".e");
    push_str("1e+");
    push_str("7lu");
    push_str("0XaL");
    push_str("1uu");
    push_str("5.1");
    run_random(220);
    for (int p = 1; p < 7; p++) begin
      drain();
      case (p)
        1: begin
          set_limit(clil_pkg::CFG_INT_MAX, 64'd32767);
          set_limit(clil_pkg::CFG_UINT_MAX, 64'd65535);
          set_limit(clil_pkg::CFG_LONG_MAX, 64'd2147483647);
          set_limit(clil_pkg::CFG_ULONG_MAX, 64'd4294967295);
        end
        2: begin
          set_limit(clil_pkg::CFG_INT_MAX, '0);
          set_limit(clil_pkg::CFG_UINT_MAX, '0);
          set_limit(clil_pkg::CFG_LONG_MAX, '0);
          set_limit(clil_pkg::CFG_ULONG_MAX, '0);
        end
        3: begin
          set_limit(clil_pkg::CFG_INT_MAX, VMASK);
          set_limit(clil_pkg::CFG_UINT_MAX, VMASK);
          set_limit(clil_pkg::CFG_LONG_MAX, VMASK);
          set_limit(clil_pkg::CFG_ULONG_MAX, VMASK);
        end
        4: begin
          set_limit(clil_pkg::CFG_INT_MAX, 64'd2147483647);
          set_limit(clil_pkg::CFG_UINT_MAX, 64'd4294967295);
          set_limit(clil_pkg::CFG_LONG_MAX, LIM63);
          set_limit(clil_pkg::CFG_ULONG_MAX, VMASK);
        end
        default: begin
          set_limit(clil_pkg::CFG_INT_MAX, {$urandom, $urandom});
          set_limit(clil_pkg::CFG_UINT_MAX, rand_wide());
          set_limit(clil_pkg::CFG_LONG_MAX, rand_wide());
          set_limit(clil_pkg::CFG_ULONG_MAX, rand_wide());
        end
      endcase
      run_random(220);
    end
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
